### rtl/ddvd_pkg.sv
// Shared types and constants for the delta-of-delta varint decoder.
// No dependencies; imported by ddvd_decode and the top level.
`default_nettype none

package ddvd_pkg;

   localparam int unsigned DataW             = 8;
   localparam int unsigned GroupW            = 7;
   localparam int unsigned ValueW            = 64;
   localparam int unsigned IndexW            = 16;
   localparam int unsigned CountW            = 17;
   localparam int unsigned ByteCntW          = 4;
   localparam int unsigned ShiftW            = 6;
   localparam int unsigned VarintMaxBytes    = 10;
   localparam int unsigned CsrIndexW         = 8;
   localparam int unsigned CsrDataW          = 32;
   localparam int unsigned DefaultMaxRecords = 65536;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexW-1:0] CSR_RECORD_COUNT = 8'd0;
   localparam logic [CsrIndexW-1:0] CSR_VALUE_WIDTH  = 8'd1;

   localparam logic [CountW-1:0] RecordCountReset = 17'd1;

   typedef enum logic [1:0] {
      WIDTH_INT8  = 2'd0,
      WIDTH_INT16 = 2'd1,
      WIDTH_INT32 = 2'd2,
      WIDTH_INT64 = 2'd3
   } ddvd_width_type;

   typedef struct packed {
      logic [DataW-1:0] data_byte;
      logic             block_start;
      logic             block_end;
   } ddvd_item_type;

   typedef struct packed {
      logic              has_result;
      logic [ValueW-1:0] value;
      logic [IndexW-1:0] value_index;
      logic              last_value;
      logic              error;
   } ddvd_result_type;

endpackage

`default_nettype wire

### rtl/ddvd_decode.sv
// Decode step of the delta-of-delta varint decoder: varint gathering,
// zigzag, delta-of-delta reconstruction and the per-block state. Uses ddvd_pkg.
`default_nettype none

module ddvd_decode #(
   parameter int unsigned MAX_RECORDS = ddvd_pkg::DefaultMaxRecords
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  ddvd_pkg::ddvd_item_type           item,
   input  logic [ddvd_pkg::CountW-1:0]       record_count,
   input  ddvd_pkg::ddvd_width_type          value_width,
   output ddvd_pkg::ddvd_result_type         result
);
   import ddvd_pkg::*;

   localparam int unsigned DoneW = $clog2(MAX_RECORDS + 1);
   localparam int unsigned CmpW  = (DoneW > CountW) ? DoneW : CountW;
   localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_RECORDS);

   logic [ValueW-1:0]   prev_value_ff, prev_value_in;
   logic [ValueW-1:0]   prev_delta_ff, prev_delta_in;
   logic [ValueW-1:0]   acc_ff, acc_in;
   logic [ByteCntW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [DoneW-1:0]    done_ff, done_in;
   logic                finished_ff, finished_in;

   logic [ValueW-1:0]   base_value, base_delta, base_acc;
   logic [ByteCntW-1:0] base_cnt;
   logic [DoneW-1:0]    base_done, done_inc;
   logic                live, more, overlong, last;
   logic [ShiftW-1:0]   shamt;
   logic [ValueW-1:0]   acc_new, zz, delta_new, cur;
   logic [CmpW-1:0]     count_cmp, eff_count;

   function automatic logic [ValueW-1:0] narrow(input logic [ValueW-1:0] v,
                                                input ddvd_width_type w);
      logic [ValueW-1:0] r;
      unique case (w)
         WIDTH_INT8:  r = {{56{v[7]}}, v[7:0]};
         WIDTH_INT16: r = {{48{v[15]}}, v[15:0]};
         WIDTH_INT32: r = {{32{v[31]}}, v[31:0]};
         WIDTH_INT64: r = v;
         default:     r = v;
      endcase
      return r;
   endfunction

   // A block start clears the state before its own byte is decoded.
   always_comb begin
      base_value = item.block_start ? '0 : prev_value_ff;
      base_delta = item.block_start ? '0 : prev_delta_ff;
      base_acc   = item.block_start ? '0 : acc_ff;
      base_cnt   = item.block_start ? '0 : byte_cnt_ff;
      base_done  = item.block_start ? '0 : done_ff;
      live       = item.block_start | ~finished_ff;

      shamt    = ShiftW'({2'b00, base_cnt} * 6'd7);
      acc_new  = base_acc | ({{(ValueW-GroupW){1'b0}}, item.data_byte[GroupW-1:0]} << shamt);
      more     = item.data_byte[DataW-1];
      overlong = more && (base_cnt == ByteCntW'(VarintMaxBytes - 1));

      zz        = (acc_new >> 1) ^ {ValueW{acc_new[0]}};
      delta_new = base_delta + zz;
      // Before the second value the stored delta is zero, so one sum serves all cases.
      cur       = base_value + base_delta + zz;
      done_inc  = base_done + 1'b1;

      count_cmp = CmpW'(record_count);
      if (count_cmp == '0) begin
         eff_count = CmpW'(1);
      end else if (count_cmp > MaxCmp) begin
         eff_count = MaxCmp;
      end else begin
         eff_count = count_cmp;
      end
      last = CmpW'(done_inc) >= eff_count;
   end

   always_comb begin
      prev_value_in      = base_value;
      prev_delta_in      = base_delta;
      acc_in             = base_acc;
      byte_cnt_in        = base_cnt;
      done_in            = base_done;
      finished_in        = item.block_start ? 1'b0 : finished_ff;
      result.has_result  = 1'b0;
      result.value       = '0;
      result.value_index = IndexW'(base_done);
      result.last_value  = 1'b0;
      result.error       = 1'b0;

      priority if (!live) begin
         finished_in = finished_ff;
      end else if (more) begin
         acc_in      = acc_new;
         byte_cnt_in = base_cnt + 1'b1;
         if (overlong || item.block_end) begin
            result.has_result = 1'b1;
            result.error      = 1'b1;
            finished_in       = 1'b1;
         end
      end else begin
         acc_in        = '0;
         byte_cnt_in   = '0;
         prev_value_in = cur;
         prev_delta_in = (base_done == '0) ? base_delta : delta_new;
         done_in       = done_inc;
         result.has_result = 1'b1;
         if (item.block_end && !last) begin
            result.error       = 1'b1;
            result.value_index = IndexW'(done_inc);
            finished_in        = 1'b1;
         end else begin
            result.value      = narrow(cur, value_width);
            result.last_value = last;
            finished_in       = last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_value_ff <= '0;
         prev_delta_ff <= '0;
         acc_ff        <= '0;
         byte_cnt_ff   <= '0;
         done_ff       <= '0;
         finished_ff   <= 1'b1;
      end else if (step_en) begin
         prev_value_ff <= prev_value_in;
         prev_delta_ff <= prev_delta_in;
         acc_ff        <= acc_in;
         byte_cnt_ff   <= byte_cnt_in;
         done_ff       <= done_in;
         finished_ff   <= finished_in;
      end
   end

endmodule

`default_nettype wire

### rtl/delta_of_delta_varint_decoder_unit.sv
// Top level of the delta-of-delta zigzag varint decoder: beat handshakes,
// configuration registers, input and result registers. Uses ddvd_pkg, ddvd_decode.
//
// A byte accepted into the input register is decoded combinationally from that
// register, and its result is captured in the result register, from which the
// result beat is offered.
// Throughput: one byte per cycle unless a result beat is held back; the 64-bit
// three-operand add of the value recurrence sits between these two registers.
// Reset (synchronous, active high) clears all block state, leaves the
// decoder waiting for a block start, and sets record_count 1, value_width int64.
`default_nettype none

module delta_of_delta_varint_decoder_unit #(
   parameter int unsigned MAX_RECORDS = ddvd_pkg::DefaultMaxRecords
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input byte channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ddvd_pkg::DataW-1:0]         req_data_byte,
   input  logic                               req_block_start,
   input  logic                               req_block_end,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ddvd_pkg::ValueW-1:0] rsp_value,
   output logic [ddvd_pkg::IndexW-1:0]        rsp_value_index,
   output logic                               rsp_last_value,
   output logic                               rsp_error,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ddvd_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [ddvd_pkg::CsrDataW-1:0]      csr_data
);
   import ddvd_pkg::*;

   // Input stage: one registered beat waiting for the decode step.
   logic            in_vld_ff, in_vld_in;
   ddvd_item_type   in_item_ff, in_item_in;
   // Result stage: the output register that parts the two channels.
   logic            rsp_vld_ff, rsp_vld_in;
   ddvd_result_type rsp_ff, rsp_in;
   // Configuration registers.
   logic [CountW-1:0] rec_count_ff, rec_count_in;
   ddvd_width_type    val_width_ff, val_width_in;

   logic            advance;
   logic            req_fire;
   logic            load_rsp;
   ddvd_result_type step_result;

   // The input beat moves on whenever the result register is free or is being
   // emptied in this cycle; beats that give no result move on the same way.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign load_rsp  = advance && step_result.has_result;

   // Configuration is always accepted; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   ddvd_decode #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .item         (in_item_ff),
      .record_count (rec_count_ff),
      .value_width  (val_width_ff),
      .result       (step_result)
   );

   always_comb begin
      in_item_in.data_byte   = req_data_byte;
      in_item_in.block_start = req_block_start;
      in_item_in.block_end   = req_block_end;

      priority if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      rsp_in = step_result;
      priority if (load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end

      rec_count_in = rec_count_ff;
      val_width_in = val_width_ff;
      if (csr_valid && csr_ready && (csr_index == CSR_RECORD_COUNT)) begin
         rec_count_in = csr_data[CountW-1:0];
      end
      if (csr_valid && csr_ready && (csr_index == CSR_VALUE_WIDTH)) begin
         val_width_in = ddvd_width_type'(csr_data[1:0]);
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         rec_count_ff <= RecordCountReset;
         val_width_ff <= WIDTH_INT64;
      end else begin
         in_vld_ff    <= in_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         rec_count_ff <= rec_count_in;
         val_width_ff <= val_width_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_value       = rsp_ff.value;
   assign rsp_value_index = rsp_ff.value_index;
   assign rsp_last_value  = rsp_ff.last_value;
   assign rsp_error       = rsp_ff.error;

   // An error result never carries a value and never closes the block normally.
   a_error_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> (rsp_value == '0) && !rsp_last_value)
      else $error("error beat carries a value or a last mark");

   // A fresh result beat only appears after an input beat has been decoded.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result beat without a decoded input beat");

   // Back-pressure on the input only comes from a held beat behind a blocked result.
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_vld_ff && rsp_vld_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   // An accepted beat always occupies the input stage at the following edge.
   a_beat_taken : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_vld_ff)
      else $error("accepted beat lost from the input stage");

endmodule

`default_nettype wire
